// ----- src/sei_pkg.sv -----
package sei_pkg;

    // Field and word widths that do not follow a parameter.
    localparam int COEF_BITS     = 32;
    localparam int NUM_COEF      = 9;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 64;
    localparam int QUOT_BITS     = 32;
    localparam int FRAC_BITS     = 16;
    localparam int ACC_BITS      = 48;
    localparam int LIMB_BITS     = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEFF_A    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEFF_B    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEFF_C    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEFF_D    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEFF_LAST = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESH     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_W     = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_H     = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [QUOT_BITS-1:0] THRESH_RESET = 32'd262144;
    localparam int HALF_W_RESET = 320;
    localparam int HALF_H_RESET = 240;

    // Length of the multiply-accumulate program.
    localparam int NUM_STEPS = 41;
    localparam int STEP_BITS = 6;

    // Operand sources for the shared multiplier.
    typedef enum logic [4:0] {
        OP_F0, OP_F1, OP_F2, OP_F3, OP_F4, OP_F5, OP_F6, OP_F7, OP_F8,
        OP_A, OP_B, OP_C, OP_D, OP_S,
        OP_L0LO, OP_L0HI, OP_L1LO, OP_L1HI, OP_L2LO, OP_L2HI, OP_L3LO, OP_L3HI,
        OP_TLO, OP_THI, OP_NLO, OP_NHI
    } t_opnd;

    // Alignment of a product in the accumulator, in whole limbs.
    typedef enum logic [1:0] {
        SH_0,
        SH_32,
        SH_64
    } t_shift;

    // Where a finished sum of products goes.
    typedef enum logic [2:0] {
        DST_L0, DST_L1, DST_L2, DST_L3, DST_T, DST_N, DST_D, DST_N2
    } t_dest;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV,
        ST_HOLD
    } t_state;

    typedef struct packed {
        t_opnd  opa;
        t_opnd  opb;
        t_shift shift;
        logic   first;
        logic   last;
        t_dest  dest;
    } t_step;

    // Control that travels with a product through the multiply-accumulate unit.
    typedef struct packed {
        logic   valid;
        logic   first;
        logic   last;
        t_shift shift;
        t_dest  dest;
    } t_mac_ctl;

    // Write-back of a finished sum.
    typedef struct packed {
        logic  valid;
        t_dest dest;
    } t_mac_wr;

    function automatic t_step mk_step(input t_opnd opa, input t_opnd opb, input t_shift shift,
                                      input logic first, input logic last, input t_dest dest);
        t_step s;
        s.opa   = opa;
        s.opb   = opb;
        s.shift = shift;
        s.first = first;
        s.last  = last;
        s.dest  = dest;
        return s;
    endfunction

    // Program of the shared multiplier: the four epipolar line terms, the
    // point term, the residual, the denominator and the squared residual.
    // Wide values enter as a low unsigned limb and a high signed limb.
    function automatic t_step step_of(input logic [STEP_BITS-1:0] idx);
        t_step s;
        unique case (idx)
            6'd0:    s = mk_step(OP_F0, OP_A, SH_0, 1'b1, 1'b0, DST_L0);
            6'd1:    s = mk_step(OP_F1, OP_B, SH_0, 1'b0, 1'b0, DST_L0);
            6'd2:    s = mk_step(OP_F2, OP_S, SH_0, 1'b0, 1'b1, DST_L0);
            6'd3:    s = mk_step(OP_F3, OP_A, SH_0, 1'b1, 1'b0, DST_L1);
            6'd4:    s = mk_step(OP_F4, OP_B, SH_0, 1'b0, 1'b0, DST_L1);
            6'd5:    s = mk_step(OP_F5, OP_S, SH_0, 1'b0, 1'b1, DST_L1);
            6'd6:    s = mk_step(OP_F0, OP_C, SH_0, 1'b1, 1'b0, DST_L2);
            6'd7:    s = mk_step(OP_F3, OP_D, SH_0, 1'b0, 1'b0, DST_L2);
            6'd8:    s = mk_step(OP_F6, OP_S, SH_0, 1'b0, 1'b1, DST_L2);
            6'd9:    s = mk_step(OP_F1, OP_C, SH_0, 1'b1, 1'b0, DST_L3);
            6'd10:   s = mk_step(OP_F4, OP_D, SH_0, 1'b0, 1'b0, DST_L3);
            6'd11:   s = mk_step(OP_F7, OP_S, SH_0, 1'b0, 1'b1, DST_L3);
            6'd12:   s = mk_step(OP_F6, OP_A, SH_0, 1'b1, 1'b0, DST_T);
            6'd13:   s = mk_step(OP_F7, OP_B, SH_0, 1'b0, 1'b0, DST_T);
            6'd14:   s = mk_step(OP_F8, OP_S, SH_0, 1'b0, 1'b1, DST_T);
            6'd15:   s = mk_step(OP_C, OP_L0LO, SH_0,  1'b1, 1'b0, DST_N);
            6'd16:   s = mk_step(OP_C, OP_L0HI, SH_32, 1'b0, 1'b0, DST_N);
            6'd17:   s = mk_step(OP_D, OP_L1LO, SH_0,  1'b0, 1'b0, DST_N);
            6'd18:   s = mk_step(OP_D, OP_L1HI, SH_32, 1'b0, 1'b0, DST_N);
            6'd19:   s = mk_step(OP_S, OP_TLO,  SH_0,  1'b0, 1'b0, DST_N);
            6'd20:   s = mk_step(OP_S, OP_THI,  SH_32, 1'b0, 1'b1, DST_N);
            6'd21:   s = mk_step(OP_L0LO, OP_L0LO, SH_0,  1'b1, 1'b0, DST_D);
            6'd22:   s = mk_step(OP_L0LO, OP_L0HI, SH_32, 1'b0, 1'b0, DST_D);
            6'd23:   s = mk_step(OP_L0HI, OP_L0LO, SH_32, 1'b0, 1'b0, DST_D);
            6'd24:   s = mk_step(OP_L0HI, OP_L0HI, SH_64, 1'b0, 1'b0, DST_D);
            6'd25:   s = mk_step(OP_L1LO, OP_L1LO, SH_0,  1'b0, 1'b0, DST_D);
            6'd26:   s = mk_step(OP_L1LO, OP_L1HI, SH_32, 1'b0, 1'b0, DST_D);
            6'd27:   s = mk_step(OP_L1HI, OP_L1LO, SH_32, 1'b0, 1'b0, DST_D);
            6'd28:   s = mk_step(OP_L1HI, OP_L1HI, SH_64, 1'b0, 1'b0, DST_D);
            6'd29:   s = mk_step(OP_L2LO, OP_L2LO, SH_0,  1'b0, 1'b0, DST_D);
            6'd30:   s = mk_step(OP_L2LO, OP_L2HI, SH_32, 1'b0, 1'b0, DST_D);
            6'd31:   s = mk_step(OP_L2HI, OP_L2LO, SH_32, 1'b0, 1'b0, DST_D);
            6'd32:   s = mk_step(OP_L2HI, OP_L2HI, SH_64, 1'b0, 1'b0, DST_D);
            6'd33:   s = mk_step(OP_L3LO, OP_L3LO, SH_0,  1'b0, 1'b0, DST_D);
            6'd34:   s = mk_step(OP_L3LO, OP_L3HI, SH_32, 1'b0, 1'b0, DST_D);
            6'd35:   s = mk_step(OP_L3HI, OP_L3LO, SH_32, 1'b0, 1'b0, DST_D);
            6'd36:   s = mk_step(OP_L3HI, OP_L3HI, SH_64, 1'b0, 1'b1, DST_D);
            6'd37:   s = mk_step(OP_NLO, OP_NLO, SH_0,  1'b1, 1'b0, DST_N2);
            6'd38:   s = mk_step(OP_NLO, OP_NHI, SH_32, 1'b0, 1'b0, DST_N2);
            6'd39:   s = mk_step(OP_NHI, OP_NLO, SH_32, 1'b0, 1'b0, DST_N2);
            6'd40:   s = mk_step(OP_NHI, OP_NHI, SH_64, 1'b0, 1'b1, DST_N2);
            default: s = mk_step(OP_F0, OP_F0, SH_0, 1'b0, 1'b0, DST_L0);
        endcase
        return s;
    endfunction

endpackage

// ----- src/sei_mac.sv -----
module sei_mac #(
    parameter int MW    = 33,
    parameter int ACC_W = 120
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sei_pkg::t_mac_ctl       i_ctl,
    input  logic signed [MW-1:0]    i_opa,
    input  logic signed [MW-1:0]    i_opb,
    output sei_pkg::t_mac_wr        o_wr,
    output logic signed [ACC_W-1:0] o_sum
);
    import sei_pkg::*;

    logic signed [2*MW-1:0]  r_prod;
    t_mac_ctl                r_ctl;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] w_term;
    logic signed [ACC_W-1:0] w_sum;

    // Product stage.
    always_ff @(posedge i_clk) begin
        r_prod <= i_opa * i_opb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // Align the product to its limb position.
    always_comb begin
        unique case (r_ctl.shift)
            SH_0:    w_term = ACC_W'(r_prod);
            SH_32:   w_term = ACC_W'(r_prod) <<< LIMB_BITS;
            SH_64:   w_term = ACC_W'(r_prod) <<< (2 * LIMB_BITS);
            default: w_term = '0;
        endcase
    end

    // The first product of a sum replaces the accumulator.
    assign w_sum = (r_ctl.first ? '0 : r_acc) + w_term;

    always_ff @(posedge i_clk) begin
        if (r_ctl.valid) begin
            r_acc <= w_sum;
        end
    end

    assign o_sum      = w_sum;
    assign o_wr.valid = r_ctl.valid & r_ctl.last;
    assign o_wr.dest  = r_ctl.dest;

endmodule

// ----- src/sei_div.sv -----
module sei_div #(
    parameter int N2W = 118,
    parameter int DW  = 92
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [N2W-1:0]                 i_n2,
    input  logic [DW-1:0]                  i_den,
    output logic                           o_done,
    output logic [sei_pkg::QUOT_BITS-1:0]  o_quot
);
    import sei_pkg::*;

    localparam int CMP_W = (N2W > DW + FRAC_BITS) ? N2W : DW + FRAC_BITS;
    localparam int CNT_W = $clog2(QUOT_BITS);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DW-1:0]        r_rem;
    logic [QUOT_BITS-1:0] r_bits;
    logic [QUOT_BITS-1:0] r_quot;

    logic                 w_den_zero;
    logic                 w_n2_zero;
    logic                 w_ovf;
    logic [DW:0]          w_trial;
    logic [DW+1:0]        w_diff;
    logic                 w_fit;

    // Short cuts: zero denominator, and a quotient that does not fit.
    assign w_den_zero = (i_den == '0);
    assign w_n2_zero  = (i_n2 == '0);
    assign w_ovf      = CMP_W'(i_n2) >= (CMP_W'(i_den) << FRAC_BITS);

    // One restoring step: bring in the next dividend bit and try a subtract.
    // The denominator is held steady by the caller while the divider runs.
    assign w_trial = {r_rem, r_bits[QUOT_BITS-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, i_den};
    assign w_fit   = ~w_diff[DW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (w_den_zero || w_ovf) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUOT_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder, dividend bits and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (w_den_zero) begin
                r_quot <= w_n2_zero ? '0 : '1;
            end else begin
                r_quot <= w_ovf ? '1 : '0;
            end
            r_rem  <= DW'(i_n2 >> FRAC_BITS);
            r_bits <= {i_n2[FRAC_BITS-1:0], {(QUOT_BITS - FRAC_BITS){1'b0}}};
        end else if (r_busy) begin
            r_rem  <= w_fit ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_quot <= {r_quot[QUOT_BITS-2:0], w_fit};
            r_bits <= r_bits << 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("Divider started while a division is running.");

endmodule

// ----- src/sampson_error_inlier_scoring_unit.sv -----
// Sampson error scoring of point correspondences against a 3x3 fundamental
// matrix, with a running inlier count and error sum.
// Configuration: a write channel (i_cfg_valid, o_cfg_ready, i_cfg_index,
// i_cfg_data) that is always ready. Write it only while the block is idle.
// Input: one correspondence word per handshake on i_valid / o_ready. The block
// takes a word only when its sequencer is idle, so it works on one at a time.
// Output: one result word per input word on o_valid / i_ready, held in an
// output register. A new input word is taken while a result still waits.
// Each word makes 41 passes through the one shared multiply-accumulate unit
// and then runs the 32-step serial divider; when the denominator is zero or
// the error saturates, the divider finishes without its serial steps.
// Reset clears the sequencer, the totals and the output valid, and loads the
// register defaults. If the receiver stalls, the finished result waits in the
// sequencer until the output register frees up; no word is lost.
// The totals include the current word and restart after a word marked last.
module sampson_error_inlier_scoring_unit #(
    parameter int COORD_BITS = 12,
    parameter int COUNT_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sei_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [sei_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [COORD_BITS-1:0]              i_first_x,
    input  logic [COORD_BITS-1:0]              i_first_y,
    input  logic [COORD_BITS-1:0]              i_second_x,
    input  logic [COORD_BITS-1:0]              i_second_y,
    input  logic                               i_last_pair,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_is_inlier,
    output logic [sei_pkg::QUOT_BITS-1:0]      o_sampson_error,
    output logic [COUNT_BITS-1:0]              o_inlier_total,
    output logic [sei_pkg::ACC_BITS-1:0]       o_error_total,
    output logic                               o_pass_done
);
    import sei_pkg::*;

    // Value widths: centered coordinate, line term, residual and products.
    localparam int PW    = COORD_BITS + 1;
    localparam int LW    = COORD_BITS + 34;
    localparam int NW    = 2 * COORD_BITS + 36;
    localparam int MW    = (NW - LIMB_BITS > 33) ? NW - LIMB_BITS : 33;
    localparam int ACC_W = 2 * NW;
    localparam int DW    = 2 * LW;
    localparam int N2W   = 2 * NW - 2;
    localparam logic signed [MW-1:0] SCALE = MW'(2 ** (COORD_BITS - 1));

    // Configuration registers.
    logic signed [COEF_BITS-1:0] r_coef [NUM_COEF];
    logic [QUOT_BITS-1:0]        r_thr;
    logic [COORD_BITS-1:0]       r_hw;
    logic [COORD_BITS-1:0]       r_hh;

    // Working values of the current word.
    logic signed [PW-1:0] r_pa, r_pb, r_pc, r_pd;
    logic                 r_last;
    logic signed [LW-1:0] r_l0, r_l1, r_l2, r_l3, r_t;
    logic signed [NW-1:0] r_n;
    logic [DW-1:0]        r_den;

    // Sequencer.
    t_state               r_state, n_state;
    logic [STEP_BITS-1:0] r_step, n_step;
    t_step                w_step;
    t_mac_ctl             w_ctl;
    t_mac_wr              w_wr;
    logic signed [MW-1:0]    w_opa, w_opb;
    logic signed [ACC_W-1:0] w_sum;
    logic                 w_load;
    logic                 w_out_free;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [QUOT_BITS-1:0] w_quot;

    // Totals and output register.
    logic [COUNT_BITS-1:0] r_cnt;
    logic [ACC_BITS-1:0]   r_err_acc;
    logic                  r_out_valid;
    logic                  r_o_inl;
    logic [QUOT_BITS-1:0]  r_o_err;
    logic [COUNT_BITS-1:0] r_o_cnt;
    logic [ACC_BITS-1:0]   r_o_acc;
    logic                  r_o_done;
    logic                  w_inl;
    logic [COUNT_BITS-1:0] w_cnt_inc;
    logic [ACC_BITS:0]     w_err_sum;
    logic [ACC_BITS-1:0]   w_err_new;

    function automatic logic signed [MW-1:0] lo_limb(input logic signed [NW-1:0] v);
        return {{(MW - LIMB_BITS){1'b0}}, v[LIMB_BITS-1:0]};
    endfunction

    function automatic logic signed [MW-1:0] hi_limb(input logic signed [NW-1:0] v);
        return MW'(v >>> LIMB_BITS);
    endfunction

    // Operand select for the shared multiplier.
    function automatic logic signed [MW-1:0] opnd_val(input t_opnd code);
        logic signed [MW-1:0] v;
        unique case (code)
            OP_F0:   v = MW'(r_coef[0]);
            OP_F1:   v = MW'(r_coef[1]);
            OP_F2:   v = MW'(r_coef[2]);
            OP_F3:   v = MW'(r_coef[3]);
            OP_F4:   v = MW'(r_coef[4]);
            OP_F5:   v = MW'(r_coef[5]);
            OP_F6:   v = MW'(r_coef[6]);
            OP_F7:   v = MW'(r_coef[7]);
            OP_F8:   v = MW'(r_coef[8]);
            OP_A:    v = MW'(r_pa);
            OP_B:    v = MW'(r_pb);
            OP_C:    v = MW'(r_pc);
            OP_D:    v = MW'(r_pd);
            OP_S:    v = SCALE;
            OP_L0LO: v = lo_limb(NW'(r_l0));
            OP_L0HI: v = hi_limb(NW'(r_l0));
            OP_L1LO: v = lo_limb(NW'(r_l1));
            OP_L1HI: v = hi_limb(NW'(r_l1));
            OP_L2LO: v = lo_limb(NW'(r_l2));
            OP_L2HI: v = hi_limb(NW'(r_l2));
            OP_L3LO: v = lo_limb(NW'(r_l3));
            OP_L3HI: v = hi_limb(NW'(r_l3));
            OP_TLO:  v = lo_limb(NW'(r_t));
            OP_THI:  v = hi_limb(NW'(r_t));
            OP_NLO:  v = lo_limb(r_n);
            OP_NHI:  v = hi_limb(r_n);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Configuration writes.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEF; k++) begin
                r_coef[k] <= '0;
            end
            r_thr <= THRESH_RESET;
            r_hw  <= COORD_BITS'(HALF_W_RESET);
            r_hh  <= COORD_BITS'(HALF_H_RESET);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COEFF_A: begin
                    r_coef[0] <= i_cfg_data[COEF_BITS-1:0];
                    r_coef[1] <= i_cfg_data[2*COEF_BITS-1:COEF_BITS];
                end
                CFG_COEFF_B: begin
                    r_coef[2] <= i_cfg_data[COEF_BITS-1:0];
                    r_coef[3] <= i_cfg_data[2*COEF_BITS-1:COEF_BITS];
                end
                CFG_COEFF_C: begin
                    r_coef[4] <= i_cfg_data[COEF_BITS-1:0];
                    r_coef[5] <= i_cfg_data[2*COEF_BITS-1:COEF_BITS];
                end
                CFG_COEFF_D: begin
                    r_coef[6] <= i_cfg_data[COEF_BITS-1:0];
                    r_coef[7] <= i_cfg_data[2*COEF_BITS-1:COEF_BITS];
                end
                CFG_COEFF_LAST: r_coef[8] <= i_cfg_data[COEF_BITS-1:0];
                CFG_THRESH:     r_thr     <= i_cfg_data[QUOT_BITS-1:0];
                CFG_HALF_W:     r_hw      <= i_cfg_data[COORD_BITS-1:0];
                CFG_HALF_H:     r_hh      <= i_cfg_data[COORD_BITS-1:0];
            endcase
        end
    end

    // Center the coordinates as the word is taken.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_pa   <= PW'({1'b0, i_first_x})  - PW'({1'b0, r_hw});
            r_pb   <= PW'({1'b0, i_first_y})  - PW'({1'b0, r_hh});
            r_pc   <= PW'({1'b0, i_second_x}) - PW'({1'b0, r_hw});
            r_pd   <= PW'({1'b0, i_second_y}) - PW'({1'b0, r_hh});
            r_last <= i_last_pair;
        end
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign w_step     = step_of(r_step);
    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        w_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_MAC;
                    n_step  = '0;
                end
            end
            ST_MAC: begin
                if (r_step == STEP_BITS'(NUM_STEPS - 1)) begin
                    n_state = ST_DIV;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // Issue one product per cycle while the program runs.
    assign w_ctl.valid = (r_state == ST_MAC);
    assign w_ctl.first = w_step.first;
    assign w_ctl.last  = w_step.last;
    assign w_ctl.shift = w_step.shift;
    assign w_ctl.dest  = w_step.dest;
    assign w_opa       = opnd_val(w_step.opa);
    assign w_opb       = opnd_val(w_step.opb);

    sei_mac #(
        .MW    (MW),
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_opa   (w_opa),
        .i_opb   (w_opb),
        .o_wr    (w_wr),
        .o_sum   (w_sum)
    );

    // Store each finished sum.
    always_ff @(posedge i_clk) begin
        if (w_wr.valid) begin
            unique case (w_wr.dest)
                DST_L0: r_l0  <= w_sum[LW-1:0];
                DST_L1: r_l1  <= w_sum[LW-1:0];
                DST_L2: r_l2  <= w_sum[LW-1:0];
                DST_L3: r_l3  <= w_sum[LW-1:0];
                DST_T:  r_t   <= w_sum[LW-1:0];
                DST_N:  r_n   <= w_sum[NW-1:0];
                DST_D:  r_den <= w_sum[DW-1:0];
                DST_N2: ;
            endcase
        end
    end

    // The squared residual goes straight into the divider.
    assign w_div_start = w_wr.valid && (w_wr.dest == DST_N2);

    sei_div #(
        .N2W (N2W),
        .DW  (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_n2    (w_sum[N2W-1:0]),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Inlier test and saturating totals.
    assign w_inl     = w_quot < r_thr;
    assign w_cnt_inc = (w_inl && (r_cnt != '1)) ? r_cnt + 1'b1 : r_cnt;
    assign w_err_sum = {1'b0, r_err_acc} + (ACC_BITS + 1)'(w_quot);
    assign w_err_new = w_err_sum[ACC_BITS] ? '1 : w_err_sum[ACC_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_err_acc   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_cnt     <= r_last ? '0 : w_cnt_inc;
                r_err_acc <= r_last ? '0 : w_err_new;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output word.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_inl  <= w_inl;
            r_o_err  <= w_quot;
            r_o_cnt  <= w_cnt_inc;
            r_o_acc  <= w_err_new;
            r_o_done <= r_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_is_inlier     = r_o_inl;
    assign o_sampson_error = r_o_err;
    assign o_inlier_total  = r_o_cnt;
    assign o_error_total   = r_o_acc;
    assign o_pass_done     = r_o_done;

    a_start_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> (r_state == ST_DIV))
        else $error("Division started outside the divide state.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_out_valid || i_ready))
        else $error("Output word overwritten before it was taken.");

    a_pass_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_last) |=> (r_cnt == '0 && r_err_acc == '0))
        else $error("Totals not cleared after the last word of a pass.");

endmodule

// ----- dv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sei_pkg::*;

    localparam int COORD_W         = 12;
    localparam int COUNT_W         = 16;
    localparam int COORD_MAX       = (1 << COORD_W) - 1;
    localparam int SETTLE_CYCLES   = 100;
    localparam int QUIET_LIMIT     = 5000;
    localparam int HOLD_CYCLES     = 600;
    localparam int PAIRS_PER_PHASE = 105;

    typedef logic signed [255:0] t_wide;

    // Shapes of fundamental matrix used to steer the stimulus.
    typedef enum int {
        MAT_ZERO,
        MAT_POINT_ONLY,
        MAT_ARBITRARY,
        MAT_ROW_DISPARITY,
        MAT_COL_DISPARITY,
        MAT_NEAR_ROW
    } t_matrix_kind;

    // One expected result word.
    typedef struct {
        logic                  inlier;
        logic [QUOT_BITS-1:0]  error;
        logic [COUNT_W-1:0]    inlier_total;
        logic [ACC_BITS-1:0]   error_total;
        logic                  done;
    } t_score;

    // Ports of the block.
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data = '0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [COORD_W-1:0]        i_first_x = '0;
    logic [COORD_W-1:0]        i_first_y = '0;
    logic [COORD_W-1:0]        i_second_x = '0;
    logic [COORD_W-1:0]        i_second_y = '0;
    logic                      i_last_pair = 1'b0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic                      o_is_inlier;
    logic [QUOT_BITS-1:0]      o_sampson_error;
    logic [COUNT_W-1:0]        o_inlier_total;
    logic [ACC_BITS-1:0]       o_error_total;
    logic                      o_pass_done;

    // Shadow copy of the configuration and the running totals.
    logic signed [COEF_BITS-1:0] coef_q [NUM_COEF];
    logic [QUOT_BITS-1:0]        thresh_q = THRESH_RESET;
    logic [COORD_W-1:0]          half_w_q = COORD_W'(HALF_W_RESET);
    logic [COORD_W-1:0]          half_h_q = COORD_W'(HALF_H_RESET);
    logic [COUNT_W-1:0]          inlier_count_q = '0;
    logic [ACC_BITS-1:0]         error_sum_q = '0;

    logic signed [COEF_BITS-1:0] matrix_buf [NUM_COEF];
    t_score                      expected_scores [$];
    int                          mismatch_count = 0;
    int                          send_idle_pct = 0;
    int                          recv_stall_pct = 0;
    int                          hold_request = 0;
    int                          hold_left = 0;
    int                          quiet_cycles = 0;

    sampson_error_inlier_scoring_unit #(
        .COORD_BITS(COORD_W),
        .COUNT_BITS(COUNT_W)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_first_x      (i_first_x),
        .i_first_y      (i_first_y),
        .i_second_x     (i_second_x),
        .i_second_y     (i_second_y),
        .i_last_pair    (i_last_pair),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_is_inlier    (o_is_inlier),
        .o_sampson_error(o_sampson_error),
        .o_inlier_total (o_inlier_total),
        .o_error_total  (o_error_total),
        .o_pass_done    (o_pass_done)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < NUM_COEF; i++) begin
            coef_q[i]     = '0;
            matrix_buf[i] = '0;
        end
    end

    // Mirror one register write into the shadow configuration.
    function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_COEFF_A, CFG_COEFF_B, CFG_COEFF_C, CFG_COEFF_D: begin
                coef_q[2 * idx]     = data[31:0];
                coef_q[2 * idx + 1] = data[63:32];
            end
            CFG_COEFF_LAST: coef_q[NUM_COEF - 1] = data[31:0];
            CFG_THRESH:     thresh_q = data[QUOT_BITS-1:0];
            CFG_HALF_W:     half_w_q = data[COORD_W-1:0];
            CFG_HALF_H:     half_h_q = data[COORD_W-1:0];
            default: ;
        endcase
    endfunction

    // Exact Sampson error of one correspondence, plus the running totals.
    function automatic t_score score_pair(input logic [COORD_W-1:0] x1, y1, x2, y2,
                                          input logic last_flag);
        t_wide               fw [NUM_COEF];
        t_wide               a, b, c, d, s, l0, l1, l2, l3, t, n, den;
        logic [255:0]        n2, dmag, quot;
        logic [ACC_BITS:0]   acc_sum;
        t_score              r;
        for (int i = 0; i < NUM_COEF; i++) fw[i] = t_wide'(coef_q[i]);
        a = t_wide'(longint'(x1) - longint'(half_w_q));
        b = t_wide'(longint'(y1) - longint'(half_h_q));
        c = t_wide'(longint'(x2) - longint'(half_w_q));
        d = t_wide'(longint'(y2) - longint'(half_h_q));
        s = t_wide'(2 ** (COORD_W - 1));

        // Epipolar lines of both points and the point term.
        l0 = fw[0] * a + fw[1] * b + fw[2] * s;
        l1 = fw[3] * a + fw[4] * b + fw[5] * s;
        l2 = fw[0] * c + fw[3] * d + fw[6] * s;
        l3 = fw[1] * c + fw[4] * d + fw[7] * s;
        t  = fw[6] * a + fw[7] * b + fw[8] * s;
        n  = c * l0 + d * l1 + s * t;
        if (n < 0) n = -n;
        n2   = n * n;
        den  = l0 * l0 + l1 * l1 + l2 * l2 + l3 * l3;
        dmag = den;

        // A zero denominator or a quotient that does not fit saturates.
        if (dmag == '0) begin
            r.error = (n2 == '0) ? '0 : '1;
        end else if (n2 >= (dmag << FRAC_BITS)) begin
            r.error = '1;
        end else begin
            quot    = (n2 << FRAC_BITS) / dmag;
            r.error = quot[QUOT_BITS-1:0];
        end

        r.inlier = r.error < thresh_q;
        if (r.inlier && inlier_count_q != {COUNT_W{1'b1}}) inlier_count_q++;
        acc_sum = {1'b0, error_sum_q} + (ACC_BITS + 1)'(r.error);
        if (acc_sum[ACC_BITS]) error_sum_q = '1;
        else error_sum_q = acc_sum[ACC_BITS-1:0];
        r.inlier_total = inlier_count_q;
        r.error_total  = error_sum_q;
        r.done         = last_flag;
        if (last_flag) begin
            inlier_count_q = '0;
            error_sum_q    = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s at %0t: got 0x%0h, expected 0x%0h", field, $realtime, got, want);
        mismatch_count++;
    endtask

    // Write one configuration register; the block must be idle.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one correspondence word and predict its result once taken.
    task automatic send_pair(input logic [COORD_W-1:0] x1, y1, x2, y2,
                             input logic last_flag);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid     <= 1'b1;
        i_first_x   <= x1;
        i_first_y   <= y1;
        i_second_x  <= x2;
        i_second_y  <= y2;
        i_last_pair <= last_flag;
        do @(posedge i_clk); while (!o_ready);
        expected_scores.insert(expected_scores.size(), score_pair(x1, y1, x2, y2, last_flag));
    endtask

    // Stop offering words and wait until every result has come back.
    task automatic wait_scores_drained();
        i_valid <= 1'b0;
        while (expected_scores.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_matrix();
        write_reg(CFG_COEFF_A, {matrix_buf[1], matrix_buf[0]});
        write_reg(CFG_COEFF_B, {matrix_buf[3], matrix_buf[2]});
        write_reg(CFG_COEFF_C, {matrix_buf[5], matrix_buf[4]});
        write_reg(CFG_COEFF_D, {matrix_buf[7], matrix_buf[6]});
        write_reg(CFG_COEFF_LAST, {$urandom, matrix_buf[8]});
    endtask

    // Translation along x or y: inliers share a row or a column, and the
    // error is half the squared offset in pixels.
    function automatic void set_disparity_matrix(input t_matrix_kind kind,
                                                 input logic signed [COEF_BITS-1:0] k);
        for (int i = 0; i < NUM_COEF; i++) matrix_buf[i] = '0;
        if (kind == MAT_COL_DISPARITY) begin
            matrix_buf[2] = k;
            matrix_buf[6] = -k;
        end else begin
            matrix_buf[5] = -k;
            matrix_buf[7] = k;
        end
    endfunction

    task automatic write_sizes(input logic [QUOT_BITS-1:0] thr,
                               input logic [COORD_W-1:0] hw, input logic [COORD_W-1:0] hh);
        write_reg(CFG_THRESH, {32'h0, thr});
        write_reg(CFG_HALF_W, {52'h0, hw});
        write_reg(CFG_HALF_H, {52'h0, hh});
    endtask

    function automatic logic [COORD_W-1:0] pick_half(input logic [COORD_W-1:0] usual);
        case ($urandom_range(4))
            0:       return '0;
            1:       return COORD_W'(2048);
            2:       return COORD_W'(COORD_MAX);
            3:       return usual;
            default: return COORD_W'($urandom_range(COORD_MAX));
        endcase
    endfunction

    function automatic logic signed [COEF_BITS-1:0] pick_scale();
        logic signed [COEF_BITS-1:0] k;
        case ($urandom_range(3))
            0:       k = 32'sh7FFF_FFFF;
            1:       k = 32'sh4000_0000;
            2:       k = -32'sh4000_0000;
            default: k = $urandom;
        endcase
        // The most negative value has no negation in 32 bits.
        if (k == 0 || k == 32'sh8000_0000) k = 32'sh0000_0001;
        return k;
    endfunction

    // New matrix, threshold and half sizes for one phase of random words.
    task automatic program_random_setting(output t_matrix_kind kind);
        int                          pick;
        logic [CFG_DATA_BITS-1:0]    word;
        logic [QUOT_BITS-1:0]        thr;
        pick = $urandom_range(9);
        case (pick)
            0:       kind = MAT_ZERO;
            1:       kind = MAT_POINT_ONLY;
            2:       kind = MAT_ARBITRARY;
            3, 4, 5: kind = MAT_ROW_DISPARITY;
            6, 7:    kind = MAT_COL_DISPARITY;
            default: kind = MAT_NEAR_ROW;
        endcase
        for (int i = 0; i < NUM_COEF; i++) matrix_buf[i] = '0;
        case (kind)
            MAT_POINT_ONLY: matrix_buf[8] = pick_scale();
            MAT_ARBITRARY: begin
                for (int i = 0; i < NUM_COEF; i++) begin
                    case ($urandom_range(5))
                        0:       matrix_buf[i] = 32'sh8000_0000;
                        1:       matrix_buf[i] = 32'sh7FFF_FFFF;
                        default: matrix_buf[i] = $urandom;
                    endcase
                end
            end
            MAT_ROW_DISPARITY, MAT_COL_DISPARITY: set_disparity_matrix(kind, pick_scale());
            MAT_NEAR_ROW: begin
                // Nearly rectified: small errors spread across all coefficients.
                set_disparity_matrix(MAT_ROW_DISPARITY,
                                     $urandom_range(1) ? 32'sh4000_0000 : -32'sh4000_0000);
                for (int i = 0; i < NUM_COEF; i++) begin
                    matrix_buf[i] = matrix_buf[i]
                                  + 32'(int'($urandom_range(1 << 20)) - (1 << 19));
                end
            end
            default: ;
        endcase
        load_matrix();

        case ($urandom_range(5))
            0:       thr = '0;
            1:       thr = '1;
            2:       thr = THRESH_RESET;
            3:       thr = 32'h0001_0000;
            default: thr = $urandom_range(1 << 20);
        endcase
        write_reg(CFG_THRESH, {$urandom, thr});
        word = {$urandom, $urandom};
        word[COORD_W-1:0] = pick_half(COORD_W'(HALF_W_RESET));
        write_reg(CFG_HALF_W, word);
        word = {$urandom, $urandom};
        word[COORD_W-1:0] = pick_half(COORD_W'(HALF_H_RESET));
        write_reg(CFG_HALF_H, word);
    endtask

    // For the disparity matrices mostly matched points with a small offset, the rest plain noise.
    task automatic send_random_pair(input t_matrix_kind kind);
        logic [COORD_W-1:0] x1, y1, x2, y2;
        int                 shifted;
        x1 = COORD_W'($urandom_range(COORD_MAX));
        y1 = COORD_W'($urandom_range(COORD_MAX));
        x2 = COORD_W'($urandom_range(COORD_MAX));
        y2 = COORD_W'($urandom_range(COORD_MAX));
        if (kind inside {MAT_ROW_DISPARITY, MAT_COL_DISPARITY, MAT_NEAR_ROW}
            && $urandom_range(4) != 0) begin
            shifted = ((kind == MAT_COL_DISPARITY) ? int'(x1) : int'(y1))
                    + int'($urandom_range(8)) - 4;
            if (shifted < 0) shifted = 0;
            if (shifted > COORD_MAX) shifted = COORD_MAX;
            if (kind == MAT_COL_DISPARITY) x2 = shifted[COORD_W-1:0];
            else y2 = shifted[COORD_W-1:0];
        end
        send_pair(x1, y1, x2, y2, $urandom_range(11) == 0);
    endtask

    // With all coefficients at reset every error is zero and every pair counts.
    task automatic test_reset_defaults();
        send_pair('0, '0, '0, '0, 1'b0);
        send_pair('1, '1, '1, '1, 1'b0);
        send_pair(12'd1234, 12'd77, 12'd3000, 12'd4000, 1'b1);
        wait_scores_drained();
    endtask

    task automatic test_directed_cases();
        // Row disparity against a threshold of 2.0: an offset of two lands
        // exactly on the limit and is rejected; a full-height offset saturates.
        set_disparity_matrix(MAT_ROW_DISPARITY, 32'sh4000_0000);
        load_matrix();
        write_sizes(32'h0002_0000, '0, '0);
        send_pair(12'd100, 12'd200, 12'd150, 12'd200, 1'b0);
        send_pair(12'd100, 12'd200, 12'd90, 12'd201, 1'b0);
        send_pair(12'd100, 12'd200, 12'd50, 12'd202, 1'b0);
        send_pair('0, '0, '1, 12'd3, 1'b0);
        send_pair('1, '1, '0, 12'd4093, 1'b0);
        send_pair('0, '0, '0, '1, 1'b1);
        wait_scores_drained();

        // A zero threshold rejects even a zero error.
        write_reg(CFG_THRESH, '0);
        send_pair(12'd5, 12'd5, 12'd9, 12'd5, 1'b1);
        wait_scores_drained();

        // Only the last coefficient set: zero denominator with a nonzero
        // residual, and a saturated error against the largest threshold.
        for (int i = 0; i < NUM_COEF; i++) matrix_buf[i] = '0;
        matrix_buf[8] = 32'sh7FFF_FFFF;
        load_matrix();
        write_reg(CFG_THRESH, {32'h0, 32'hFFFF_FFFF});
        send_pair('0, '0, '0, '0, 1'b0);
        send_pair('1, '0, '0, '1, 1'b1);
        wait_scores_drained();

        // Extreme coefficients and half sizes at the corners of the image.
        for (int i = 0; i < NUM_COEF; i++) matrix_buf[i] = 32'sh8000_0000;
        load_matrix();
        write_sizes(THRESH_RESET, '1, COORD_W'(2048));
        send_pair('0, '0, '0, '0, 1'b0);
        send_pair('1, '1, '1, '1, 1'b0);
        send_pair('0, '1, '1, '0, 1'b0);
        wait_scores_drained();
        for (int i = 0; i < NUM_COEF; i++) matrix_buf[i] = 32'sh7FFF_FFFF;
        load_matrix();
        write_sizes(THRESH_RESET, COORD_W'(2048), '0);
        send_pair('1, '0, '0, '1, 1'b1);
        send_pair('0, '0, '1, '1, 1'b1);
        wait_scores_drained();
    endtask

    // The receiver holds off long enough that the block stops taking words.
    task automatic test_input_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_disparity_matrix(MAT_ROW_DISPARITY, pick_scale());
        load_matrix();
        write_sizes(THRESH_RESET, COORD_W'(HALF_W_RESET), COORD_W'(HALF_H_RESET));
        hold_request = HOLD_CYCLES;
        repeat (8) send_random_pair(MAT_ROW_DISPARITY);
        wait_scores_drained();
    endtask

    task automatic test_random_phases();
        t_matrix_kind kind;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            for (int j = 0; j < 4; j++) begin
                wait_scores_drained();
                program_random_setting(kind);
                repeat (PAIRS_PER_PHASE) send_random_pair(kind);
            end
        end
        wait_scores_drained();
    endtask

    // Receiver side: random stalls, long hold-offs, and the result check.
    always @(posedge i_clk) begin : result_check
        t_score want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_scores.size() == 0) begin
                report_mismatch("result word with nothing expected", 64'(o_sampson_error), '0);
            end else begin
                want = expected_scores.pop_front();
                if (o_is_inlier !== want.inlier)
                    report_mismatch("is_inlier", 64'(o_is_inlier), 64'(want.inlier));
                if (o_sampson_error !== want.error)
                    report_mismatch("sampson_error", 64'(o_sampson_error), 64'(want.error));
                if (o_inlier_total !== want.inlier_total)
                    report_mismatch("inlier_total", 64'(o_inlier_total),
                                    64'(want.inlier_total));
                if (o_error_total !== want.error_total)
                    report_mismatch("error_total", 64'(o_error_total), 64'(want.error_total));
                if (o_pass_done !== want.done)
                    report_mismatch("pass_done", 64'(o_pass_done), 64'(want.done));
            end
        end
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // End the run if no word moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : run_tests
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed_cases();
        test_input_backpressure();
        test_random_phases();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_scores.size() != 0)
            report_mismatch("results never delivered", 64'(expected_scores.size()), '0);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/sei_pkg.sv
src/sei_mac.sv
src/sei_div.sv
src/sampson_error_inlier_scoring_unit.sv
dv/testbench.sv
